FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define CIGSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define CIGSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/cigsd_pkg.sv
// Shared types, character codes and decode helpers for the CIGAR decoder.
`timescale 1ns / 1ps

package cigsd_pkg;

    localparam logic [7:0]  CHAR_STAR = 8'h2A;
    localparam logic [7:0]  CHAR_ZERO = 8'h30;
    localparam logic [7:0]  CHAR_NINE = 8'h39;
    localparam logic [7:0]  CHAR_S    = 8'h53;
    localparam logic [7:0]  CHAR_M    = 8'h4D;
    localparam logic [7:0]  CHAR_X    = 8'h58;
    localparam logic [7:0]  CHAR_I    = 8'h49;
    localparam logic [7:0]  CHAR_H    = 8'h48;
    localparam logic [7:0]  CHAR_D    = 8'h44;
    localparam logic [7:0]  CHAR_N    = 8'h4E;

    localparam logic [27:0] LEN_SAT   = 28'h0FFFFFFF;
    localparam logic [31:0] SUM_SAT   = 32'hFFFFFFFF;

    typedef enum logic [2:0] {
        KIND_S = 3'd0,
        KIND_M = 3'd1,
        KIND_X = 3'd2,
        KIND_I = 3'd3,
        KIND_H = 3'd4,
        KIND_D = 3'd5,
        KIND_N = 3'd6
    } op_kind_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_UNALIGNED  = 3'd1,
        ST_NO_NUMBER  = 3'd2,
        ST_NO_LETTER  = 3'd3,
        ST_BAD_LETTER = 3'd4
    } status_t;

    typedef struct packed {
        logic [27:0] acc;
        logic        have_digits;
        logic [31:0] read_sum;
        logic [27:0] softclip_max;
        logic [31:0] cursor;
        logic        hardclip_seen;
        logic        at_start;
        logic        error_skip;
    } dec_state_t;

    typedef struct packed {
        op_kind_t    op_kind;
        logic [27:0] op_length;
        logic [31:0] read_length;
        logic [27:0] max_softclip;
        logic [31:0] ref_end;
        logic        hard_clipped;
        status_t     status;
        logic        record_done;
    } dec_result_t;

    typedef struct packed {
        logic     known;
        op_kind_t kind;
    } kind_dec_t;

    function automatic kind_dec_t decode_kind(input logic [7:0] c);
        kind_dec_t d;
        d.known = 1'b1;
        d.kind  = KIND_S;
        case (c)
            CHAR_S:  d.kind = KIND_S;
            CHAR_M:  d.kind = KIND_M;
            CHAR_X:  d.kind = KIND_X;
            CHAR_I:  d.kind = KIND_I;
            CHAR_H:  d.kind = KIND_H;
            CHAR_D:  d.kind = KIND_D;
            CHAR_N:  d.kind = KIND_N;
            default: d.known = 1'b0;
        endcase
        return d;
    endfunction

endpackage

FILE: design/cigsd_if.sv
// Valid/ready channel interfaces for CIGAR characters and decoded operations.
`timescale 1ns / 1ps

interface cigsd_char_if;
    logic        valid;
    logic        ready;
    logic [7:0]  cigar_char;
    logic        last_char;
    logic [31:0] ref_start;

    modport source (output valid, cigar_char, last_char, ref_start, input ready);
    modport sink   (input valid, cigar_char, last_char, ref_start, output ready);
endinterface

interface cigsd_op_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op_kind;
    logic [27:0] op_length;
    logic [31:0] read_length;
    logic [27:0] max_softclip;
    logic [31:0] ref_end;
    logic        hard_clipped;
    logic [2:0]  status;
    logic        record_done;

    modport source (output valid, op_kind, op_length, read_length, max_softclip, ref_end,
                    hard_clipped, status, record_done, input ready);
    modport sink   (input valid, op_kind, op_length, read_length, max_softclip, ref_end,
                    hard_clipped, status, record_done, output ready);
endinterface

FILE: design/cigsd_step.sv
// Combinational decode of one character against the current record state.
`timescale 1ns / 1ps

module cigsd_step (
    input  cigsd_pkg::dec_state_t  cur,
    input  logic [7:0]             cigar_char,
    input  logic                   last_char,
    input  logic [31:0]            ref_start,
    output cigsd_pkg::dec_state_t  nxt,
    output logic                   emit,
    output cigsd_pkg::dec_result_t res
);
    import cigsd_pkg::*;

    dec_state_t  s;
    kind_dec_t   kd;
    logic        first;
    logic        is_digit;
    logic [31:0] acc_x10;
    logic [32:0] sum_ext;
    logic [27:0] len;

    always_comb
    begin
        s        = cur;
        first    = cur.at_start;
        kd       = decode_kind(cigar_char);
        is_digit = (cigar_char >= CHAR_ZERO) && (cigar_char <= CHAR_NINE);
        emit     = 1'b0;
        len      = 28'd0;
        res.op_kind     = KIND_S;
        res.op_length   = 28'd0;
        res.status      = ST_OK;
        res.record_done = 1'b1;

        if (first)
        begin
            s.cursor        = ref_start;
            s.read_sum      = 32'd0;
            s.softclip_max  = 28'd0;
            s.hardclip_seen = 1'b0;
            s.acc           = 28'd0;
            s.have_digits   = 1'b0;
            s.error_skip    = 1'b0;
            s.at_start      = 1'b0;
        end

        // Multiply by ten as two shifts; the result never exceeds 32 bits.
        acc_x10 = ({4'd0, s.acc} << 3) + ({4'd0, s.acc} << 1)
                + {28'd0, cigar_char[3:0]};

        if (s.error_skip)
        begin
            if (last_char)
            begin
                s.error_skip = 1'b0;
                s.at_start   = 1'b1;
            end
        end
        else if (first && (cigar_char == CHAR_STAR))
        begin
            emit         = 1'b1;
            res.status   = ST_UNALIGNED;
            s.error_skip = !last_char;
            s.at_start   = last_char;
        end
        else if (is_digit)
        begin
            s.acc         = (acc_x10 > {4'd0, LEN_SAT}) ? LEN_SAT : acc_x10[27:0];
            s.have_digits = 1'b1;
            if (last_char)
            begin
                emit       = 1'b1;
                res.status = ST_NO_LETTER;
                s.at_start = 1'b1;
            end
        end
        else if (!s.have_digits || !kd.known)
        begin
            emit         = 1'b1;
            res.status   = s.have_digits ? ST_BAD_LETTER : ST_NO_NUMBER;
            s.error_skip = !last_char;
            s.at_start   = last_char;
        end
        else
        begin
            len           = s.acc;
            s.acc         = 28'd0;
            s.have_digits = 1'b0;
            emit          = 1'b1;
            res.op_kind   = kd.kind;
            res.op_length = len;
            res.record_done = last_char;
            s.at_start    = last_char;
        end

        // Totals only move on a well-formed operation.
        sum_ext = {1'b0, s.read_sum} + {5'd0, len};
        if (emit && (res.status == ST_OK))
        begin
            case (kd.kind)
                KIND_S:
                begin
                    s.read_sum = sum_ext[32] ? SUM_SAT : sum_ext[31:0];
                    if (len > s.softclip_max)
                    begin
                        s.softclip_max = len;
                    end
                end
                KIND_I:
                begin
                    s.read_sum = sum_ext[32] ? SUM_SAT : sum_ext[31:0];
                end
                KIND_H:
                begin
                    s.read_sum      = sum_ext[32] ? SUM_SAT : sum_ext[31:0];
                    s.hardclip_seen = 1'b1;
                end
                KIND_M, KIND_X:
                begin
                    s.read_sum = sum_ext[32] ? SUM_SAT : sum_ext[31:0];
                    s.cursor   = s.cursor + {4'd0, len};
                end
                KIND_D, KIND_N:
                begin
                    s.cursor = s.cursor + {4'd0, len};
                end
                default:
                begin
                    s.cursor = s.cursor;
                end
            endcase
        end

        res.read_length  = s.read_sum;
        res.max_softclip = s.softclip_max;
        res.ref_end      = s.cursor - 32'd1;
        res.hard_clipped = s.hardclip_seen;
        nxt              = s;
    end

endmodule

FILE: design/cigar_stream_decoder.sv
// Top level of the streaming CIGAR decoder: input stage, record state, result register.
`timescale 1ns / 1ps
//
// Usage: the cigar channel carries one CIGAR character per request, with
// last_char set on the final character of a record and ref_start valid on
// the first character of each record. The ops channel returns one request
// per operation letter, or one status request for a malformed or unaligned
// record; digits and skipped characters return nothing.
// An accepted character is held in the input register, then decoded with
// the state update, which loads the result register that drives ops.valid.
// One character is accepted every cycle while the result register is free
// or being taken; the rate is set by the state update (multiply by ten,
// saturating 32-bit add and reference cursor add).
// When the receiver stalls with a result waiting, the input stage holds its
// character and cigar.ready drops until the result is taken.
// Reset clears both stages and the record state, so the next character
// starts a new record.
//
module cigar_stream_decoder (
    input  logic         clk,
    input  logic         rst_n,
    cigsd_char_if.sink   cigar,
    cigsd_op_if.source   ops
);
    import cigsd_pkg::*;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  char_reg;
    logic        last_reg;
    logic [31:0] start_reg;

    dec_state_t  state_reg;
    dec_state_t  state_next;
    logic        step_emit;
    dec_result_t step_res;

    logic        out_valid_reg;
    logic        out_valid_next;
    dec_result_t res_reg;

    logic        advance;
    logic        take_in;
    logic        load_out;

    // The decode stage moves only when the result register is free or emptying.
    assign advance  = in_valid_reg && (!out_valid_reg || ops.ready);
    assign take_in  = cigar.valid && cigar.ready;
    assign load_out = advance && step_emit;

    assign cigar.ready = !in_valid_reg || advance;

    assign in_valid_next  = take_in ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = load_out ? 1'b1 : (ops.ready ? 1'b0 : out_valid_reg);

    cigsd_step u_step (
        .cur        (state_reg),
        .cigar_char (char_reg),
        .last_char  (last_reg),
        .ref_start  (start_reg),
        .nxt        (state_next),
        .emit       (step_emit),
        .res        (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{acc: 28'd0, have_digits: 1'b0, read_sum: 32'd0,
                               softclip_max: 28'd0, cursor: 32'd0,
                               hardclip_seen: 1'b0, at_start: 1'b1,
                               error_skip: 1'b0};
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            char_reg  <= cigar.cigar_char;
            last_reg  <= cigar.last_char;
            start_reg <= cigar.ref_start;
        end
        if (load_out)
        begin
            res_reg <= step_res;
        end
    end

    assign ops.valid        = out_valid_reg;
    assign ops.op_kind      = res_reg.op_kind;
    assign ops.op_length    = res_reg.op_length;
    assign ops.read_length  = res_reg.read_length;
    assign ops.max_softclip = res_reg.max_softclip;
    assign ops.ref_end      = res_reg.ref_end;
    assign ops.hard_clipped = res_reg.hard_clipped;
    assign ops.status       = res_reg.status;
    assign ops.record_done  = res_reg.record_done;

endmodule

FILE: design/cigsd_checker.sv
// Port-level checks on the CIGAR decoder, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cigsd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  op_kind,
    input logic [27:0] op_length,
    input logic [2:0]  status,
    input logic        record_done
);
    import cigsd_pkg::*;

    logic status_bad;

    assign status_bad = (status != ST_OK);

    `CIGSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped under stall")
    `CIGSD_ASSERT(a_err_done, !(out_valid && status_bad) || record_done, "status without record end")
    `CIGSD_ASSERT(a_err_empty, !(out_valid && status_bad) || (op_kind == KIND_S && op_length == 28'd0), "status carries an operation")
    `CIGSD_ASSERT(a_status_code, !out_valid || (status <= ST_BAD_LETTER), "status code out of range")
    `CIGSD_ASSERT(a_kind_code, !out_valid || (op_kind <= KIND_N), "operation code out of range")

endmodule

bind cigar_stream_decoder cigsd_checker u_cigsd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (ops.valid),
    .out_ready   (ops.ready),
    .op_kind     (ops.op_kind),
    .op_length   (ops.op_length),
    .status      (ops.status),
    .record_done (ops.record_done)
);

FILE: bench/cigar_check_pkg.sv
// Predictor and result checker for the CIGAR decoder bench.
`timescale 1ns / 1ps

package cigar_check_pkg;
    import cigsd_pkg::*;

    class cigar_decode_model;
        logic [27:0] acc;
        bit          have_digits;
        logic [31:0] read_sum;
        logic [27:0] clip_max;
        logic [31:0] cursor;
        bit          hard_seen;
        bit          at_start;
        bit          skipping;
        dec_result_t expected_ops[$];
        int          failures;

        function new();
            acc         = '0;
            have_digits = 1'b0;
            read_sum    = '0;
            clip_max    = '0;
            cursor      = '0;
            hard_seen   = 1'b0;
            at_start    = 1'b1;
            skipping    = 1'b0;
            failures    = 0;
        endfunction

        function int pending();
            return expected_ops.size();
        endfunction

        function void queue_op(op_kind_t kind, logic [27:0] len, status_t st, bit done);
            dec_result_t r;
            r.op_kind      = kind;
            r.op_length    = len;
            r.read_length  = read_sum;
            r.max_softclip = clip_max;
            r.ref_end      = cursor - 32'd1;
            r.hard_clipped = hard_seen;
            r.status       = st;
            r.record_done  = done;
            expected_ops.push_back(r);
        endfunction

        // Returns 0 for a character that falls in the skipped tail of a bad record.
        function bit take_char(logic [7:0] c, bit last, logic [31:0] start);
            bit          first;
            bit          known;
            op_kind_t    kind;
            logic [35:0] prod;
            logic [32:0] sum;
            logic [27:0] len;
            first = at_start;
            if (first)
            begin
                cursor      = start;
                read_sum    = '0;
                clip_max    = '0;
                hard_seen   = 1'b0;
                acc         = '0;
                have_digits = 1'b0;
                skipping    = 1'b0;
                at_start    = 1'b0;
            end
            if (skipping)
            begin
                if (last)
                begin
                    skipping = 1'b0;
                    at_start = 1'b1;
                end
                return 1'b0;
            end
            if (first && c == CHAR_STAR)
            begin
                queue_op(KIND_S, '0, ST_UNALIGNED, 1'b1);
                skipping = !last;
                at_start = last;
                return 1'b1;
            end
            if (c >= CHAR_ZERO && c <= CHAR_NINE)
            begin
                prod = 36'(acc) * 36'd10 + 36'(c - CHAR_ZERO);
                acc  = (prod > 36'(LEN_SAT)) ? LEN_SAT : prod[27:0];
                have_digits = 1'b1;
                if (last)
                begin
                    queue_op(KIND_S, '0, ST_NO_LETTER, 1'b1);
                    at_start = 1'b1;
                end
                return 1'b1;
            end
            known = 1'b1;
            kind  = KIND_S;
            case (c)
                CHAR_S:  kind = KIND_S;
                CHAR_M:  kind = KIND_M;
                CHAR_X:  kind = KIND_X;
                CHAR_I:  kind = KIND_I;
                CHAR_H:  kind = KIND_H;
                CHAR_D:  kind = KIND_D;
                CHAR_N:  kind = KIND_N;
                default: known = 1'b0;
            endcase
            if (!have_digits || !known)
            begin
                queue_op(KIND_S, '0, have_digits ? ST_BAD_LETTER : ST_NO_NUMBER, 1'b1);
                skipping = !last;
                at_start = last;
                return 1'b1;
            end
            len         = acc;
            acc         = '0;
            have_digits = 1'b0;
            if (kind <= KIND_H)
            begin
                sum      = {1'b0, read_sum} + 33'(len);
                read_sum = sum[32] ? SUM_SAT : sum[31:0];
            end
            if (kind == KIND_S && len > clip_max)
                clip_max = len;
            if (kind == KIND_H)
                hard_seen = 1'b1;
            if (kind == KIND_M || kind == KIND_X || kind == KIND_D || kind == KIND_N)
                cursor = cursor + 32'(len);
            queue_op(kind, len, ST_OK, last);
            at_start = last;
            return 1'b1;
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= 10)
                $display("%s", msg);
        endfunction

        function void match_op(dec_result_t got);
            dec_result_t want;
            if (expected_ops.size() == 0)
            begin
                note_failure($sformatf("unexpected op: kind=%0d len=%0d status=%0d",
                                       got.op_kind, got.op_length, got.status));
                return;
            end
            want = expected_ops.pop_front();
            if (got.op_kind !== want.op_kind || got.op_length !== want.op_length ||
                got.read_length !== want.read_length ||
                got.max_softclip !== want.max_softclip || got.ref_end !== want.ref_end ||
                got.hard_clipped !== want.hard_clipped || got.status !== want.status ||
                got.record_done !== want.record_done)
                note_failure($sformatf({"op mismatch: expected kind=%0d len=%0d rlen=%0d ",
                    "clip=%0d end=%h hc=%0d st=%0d done=%0d; got kind=%0d len=%0d ",
                    "rlen=%0d clip=%0d end=%h hc=%0d st=%0d done=%0d"},
                    want.op_kind, want.op_length, want.read_length, want.max_softclip,
                    want.ref_end, want.hard_clipped, want.status, want.record_done,
                    got.op_kind, got.op_length, got.read_length, got.max_softclip,
                    got.ref_end, got.hard_clipped, got.status, got.record_done));
        endfunction
    endclass

endpackage

FILE: bench/tb_cigar_stream_decoder.sv
// Self-checking bench for the streaming CIGAR decoder.
`timescale 1ns / 1ps

module tb_cigar_stream_decoder;
    import cigsd_pkg::*;
    import cigar_check_pkg::*;

    logic clk;
    logic rst_n;
    int   src_idle_pct;
    int   sink_stall_pct;
    int   chars_decoded;

    cigar_decode_model cigar_model = new();

    cigsd_char_if char_ch();
    cigsd_op_if   op_ch();

    cigar_stream_decoder DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cigar (char_ch),
        .ops   (op_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Result side: check every accepted request, then decide whether to stall.
    initial
    begin
        dec_result_t got;
        op_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && op_ch.valid && op_ch.ready)
            begin
                got.op_kind      = op_kind_t'(op_ch.op_kind);
                got.op_length    = op_ch.op_length;
                got.read_length  = op_ch.read_length;
                got.max_softclip = op_ch.max_softclip;
                got.ref_end      = op_ch.ref_end;
                got.hard_clipped = op_ch.hard_clipped;
                got.status       = status_t'(op_ch.status);
                got.record_done  = op_ch.record_done;
                cigar_model.match_op(got);
            end
            op_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    task automatic send_char(input logic [7:0] c, input logic last, input logic [31:0] start);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            char_ch.valid <= 1'b0;
            @(posedge clk);
        end
        char_ch.valid      <= 1'b1;
        char_ch.cigar_char <= c;
        char_ch.last_char  <= last;
        char_ch.ref_start  <= start;
        do
            @(posedge clk);
        while (!char_ch.ready);
        if (cigar_model.take_char(c, last, start))
            chars_decoded++;
    endtask

    // Only the first character's start position matters; the rest get noise.
    task automatic send_record(input logic [7:0] rec[$], input logic [31:0] start);
        for (int i = 0; i < rec.size(); i++)
            send_char(rec[i], i == rec.size() - 1, (i == 0) ? start : $urandom);
    endtask

    task automatic send_text(input string txt, input logic [31:0] start);
        logic [7:0] rec[$];
        for (int i = 0; i < txt.len(); i++)
            rec.push_back(txt[i]);
        send_record(rec, start);
    endtask

    function automatic void add_number(ref logic [7:0] rec[$], input longint unsigned n,
                                       input int zeros);
        string txt;
        txt = $sformatf("%0d", n);
        repeat (zeros) rec.push_back(CHAR_ZERO);
        for (int i = 0; i < txt.len(); i++)
            rec.push_back(txt[i]);
    endfunction

    function automatic logic [7:0] pick_letter();
        logic [7:0] c;
        case ($urandom_range(0, 6))
            0:       c = CHAR_S;
            1:       c = CHAR_M;
            2:       c = CHAR_X;
            3:       c = CHAR_I;
            4:       c = CHAR_H;
            5:       c = CHAR_D;
            default: c = CHAR_N;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] pick_odd_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while ((c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_S || c == CHAR_M ||
               c == CHAR_X || c == CHAR_I || c == CHAR_H || c == CHAR_D || c == CHAR_N);
        return c;
    endfunction

    function automatic logic [31:0] pick_start();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 32'($urandom_range(0, 3));
        else if (r < 30)
            return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
        return $urandom;
    endfunction

    function automatic void add_ops(ref logic [7:0] rec[$], input int count);
        int              r;
        longint unsigned n;
        int              zeros;
        for (int i = 0; i < count; i++)
        begin
            r     = $urandom_range(0, 99);
            zeros = 0;
            if (r < 60)
                n = $urandom_range(0, 99);
            else if (r < 85)
                n = $urandom_range(0, 99999);
            else if (r < 93)
                n = $urandom;
            else if (r < 97)
                n = {$urandom, $urandom};
            else
            begin
                zeros = $urandom_range(1, 3);
                n     = $urandom_range(0, 9);
            end
            add_number(rec, n, zeros);
            rec.push_back(pick_letter());
        end
    endfunction

    // Mostly well-formed records; the rest are the malformed shapes and noise.
    function automatic void build_record(ref logic [7:0] rec[$]);
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            add_ops(rec, $urandom_range(1, 6));
        else if (r < 80)
        begin
            rec.push_back(CHAR_STAR);
            repeat ($urandom_range(0, 3)) rec.push_back(8'($urandom_range(0, 255)));
        end
        else if (r < 85)
        begin
            add_ops(rec, $urandom_range(0, 2));
            add_number(rec, $urandom_range(0, 999), 0);
        end
        else if (r < 90)
        begin
            add_ops(rec, $urandom_range(0, 2));
            add_number(rec, $urandom_range(1, 99), 0);
            rec.push_back(pick_odd_char());
            repeat ($urandom_range(0, 3)) rec.push_back(8'($urandom_range(0, 255)));
        end
        else if (r < 95)
        begin
            add_ops(rec, $urandom_range(0, 2));
            rec.push_back(pick_letter());
            repeat ($urandom_range(0, 3)) rec.push_back(8'($urandom_range(0, 255)));
        end
        else
            repeat ($urandom_range(1, 6)) rec.push_back(8'($urandom_range(0, 255)));
    endfunction

    initial
    begin
        logic [7:0] rec[$];
        rst_n              = 1'b0;
        char_ch.valid      = 1'b0;
        char_ch.cigar_char = '0;
        char_ch.last_char  = 1'b0;
        char_ch.ref_start  = '0;
        src_idle_pct       = 0;
        sink_stall_pct     = 0;
        chars_decoded      = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("*", 32'd0);
        send_text("*3M", 32'h1234_5678);
        send_text("M", 32'hFFFF_FFFF);
        send_text("7", 32'd5);
        send_text("5*", 32'd9);
        send_text("0M", 32'd0);
        send_text("2M1S1H1X1I1D1N", 32'hFFFF_FFFF);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 74;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 74;
                end
                default:
                begin
                    src_idle_pct   = 17;
                    sink_stall_pct = 17;
                end
            endcase
            if (phase == 0)
            begin
                // Enough saturated lengths to pin the read length at its ceiling.
                rec.delete();
                add_number(rec, 64'd4294967295, 0);
                rec.push_back(CHAR_S);
                repeat (17)
                begin
                    add_number(rec, 64'd999999999, 0);
                    rec.push_back(CHAR_H);
                end
                add_number(rec, 64'd1, 0);
                rec.push_back(CHAR_M);
                send_record(rec, pick_start());
            end
            while (chars_decoded < 25 + (phase + 1) * 170)
            begin
                rec.delete();
                build_record(rec);
                send_record(rec, pick_start());
            end
        end
        char_ch.valid <= 1'b0;

        while (cigar_model.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (cigar_model.failures == 0 && cigar_model.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/cigsd_pkg.sv
design/cigsd_if.sv
design/cigsd_step.sv
design/cigar_stream_decoder.sv
design/cigsd_checker.sv
bench/cigar_check_pkg.sv
bench/tb_cigar_stream_decoder.sv
